FILE: rtl/wlm_pkg.sv
// ----------------------------------------------------------------------------
// Windowed load monitor package
// Shared types, operation codes, register indexes and constants.
// ----------------------------------------------------------------------------
package wlm_pkg;

    // Default widths of the window counters and the window sums.
    localparam int COUNTER_WIDTH_DEF = 32;
    localparam int TOTAL_WIDTH_DEF   = 48;

    // Fixed field widths.
    localparam int OP_W      = 3;
    localparam int AMOUNT_W  = 32;
    localparam int ELAPSED_W = 32;
    localparam int PEAK_W    = 32;
    localparam int CORE_W    = 11;
    localparam int LIMIT_W   = 32;
    localparam int PCT_LIM_W = 10;
    localparam int WLEN_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int OPS_W     = 42;
    localparam int PCT_W     = 24;
    localparam int OUT_CNT_W = 32;
    localparam int OUT_SUM_W = 48;

    // Scale factors of the query results.
    localparam int RATE_SCALE     = 1000;
    localparam int PCT_Q8_SCALE   = 25600;
    localparam int PCT_SCALE      = 100;
    // Bits needed to hold any of the products above a counter.
    localparam int PCT_Q8_SCALE_W = 15;
    localparam int PCT_SCALE_W    = 7;

    // Register reset values.
    localparam logic [CORE_W-1:0]    CORE_COUNT_RST     = CORE_W'(1);
    localparam logic [CORE_W-1:0]    CORE_THRESHOLD_RST = CORE_W'(8);
    localparam logic [LIMIT_W-1:0]   RATE_LIMIT_RST     = LIMIT_W'(50000);
    localparam logic [PCT_LIM_W-1:0] CONT_LIMIT_RST     = PCT_LIM_W'(30);
    localparam logic [LIMIT_W-1:0]   LATENCY_LIMIT_RST  = LIMIT_W'(5000);
    localparam logic [WLEN_W-1:0]    WINDOW_LENGTH_RST  = WLEN_W'(1000);

    // Operation codes of an input word.
    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_START   = 3'd1;
    localparam logic [OP_W-1:0] OP_END     = 3'd2;
    localparam logic [OP_W-1:0] OP_CONTEND = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CORE_COUNT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORE_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONT_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LATENCY_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = 3'd5;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV_RATE,
        S_WAIT_RATE,
        S_DIV_PCT,
        S_WAIT_PCT,
        S_DECIDE,
        S_EMIT
    } t_state;

endpackage

FILE: rtl/wlm_div.sv
// ----------------------------------------------------------------------------
// Windowed load monitor divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wlm_div #(
    parameter int NUM_W = 47,
    parameter int DEN_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_numer,
    input  logic [DEN_W-1:0] i_denom,
    output logic             o_busy,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   w_rem_sh;
    logic             w_fit;
    logic [DEN_W:0]   w_rem_nx;

    // One step: bring down the next numerator bit and try the subtraction.
    always_comb begin
        w_rem_sh = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
        w_fit    = (w_rem_sh >= {1'b0, r_den});
        w_rem_nx = w_fit ? (w_rem_sh - {1'b0, r_den}) : w_rem_sh;
    end

    // Control: busy while the quotient bits are produced, then a one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the numerator shifts out as the quotient shifts in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_numer;
            r_rem <= '0;
            r_den <= i_denom;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], w_fit};
            r_rem <= w_rem_nx;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

FILE: rtl/wlm_window.sv
// ----------------------------------------------------------------------------
// Windowed load monitor window state
// Saturating counters, sums, latency peak and elapsed time of the window.
// ----------------------------------------------------------------------------
module wlm_window #(
    parameter int COUNTER_WIDTH = wlm_pkg::COUNTER_WIDTH_DEF,
    parameter int TOTAL_WIDTH   = wlm_pkg::TOTAL_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_apply,
    input  logic [wlm_pkg::OP_W-1:0]      i_operation,
    input  logic [wlm_pkg::AMOUNT_W-1:0]  i_amount_us,
    input  logic [wlm_pkg::WLEN_W-1:0]    i_window_length_ms,
    output logic                          o_roll_due,
    output logic [wlm_pkg::ELAPSED_W-1:0] o_elapsed_ms,
    output logic [COUNTER_WIDTH-1:0]      o_op_counter,
    output logic [COUNTER_WIDTH-1:0]      o_contention_counter,
    output logic [TOTAL_WIDTH-1:0]        o_latency_sum,
    output logic [TOTAL_WIDTH-1:0]        o_wait_sum,
    output logic [wlm_pkg::PEAK_W-1:0]    o_latency_peak
);

    logic [wlm_pkg::ELAPSED_W-1:0] r_elapsed;
    logic [COUNTER_WIDTH-1:0]      r_ops;
    logic [COUNTER_WIDTH-1:0]      r_conts;
    logic [TOTAL_WIDTH-1:0]        r_lat_sum;
    logic [TOTAL_WIDTH-1:0]        r_wait_sum;
    logic [wlm_pkg::PEAK_W-1:0]    r_peak;

    logic [TOTAL_WIDTH:0]          w_lat_add;
    logic [TOTAL_WIDTH:0]          w_wait_add;

    // Sums with a carry bit so that an overflow saturates.
    always_comb begin
        w_lat_add  = {1'b0, r_lat_sum} + (TOTAL_WIDTH + 1)'(i_amount_us);
        w_wait_add = {1'b0, r_wait_sum} + (TOTAL_WIDTH + 1)'(i_amount_us);
    end

    // The window restarts on an operation start once it has run its length.
    assign o_roll_due = (r_elapsed >= wlm_pkg::ELAPSED_W'(i_window_length_ms));

    // Update of the window state by one event word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed  <= '0;
            r_ops      <= '0;
            r_conts    <= '0;
            r_lat_sum  <= '0;
            r_wait_sum <= '0;
            r_peak     <= '0;
        end else if (i_apply) begin
            case (i_operation)
                wlm_pkg::OP_TICK: begin
                    if (r_elapsed != '1) begin
                        r_elapsed <= r_elapsed + wlm_pkg::ELAPSED_W'(1);
                    end
                end
                wlm_pkg::OP_START: begin
                    if (o_roll_due) begin
                        r_elapsed  <= '0;
                        r_ops      <= '0;
                        r_conts    <= '0;
                        r_lat_sum  <= '0;
                        r_wait_sum <= '0;
                        r_peak     <= '0;
                    end
                end
                wlm_pkg::OP_END: begin
                    if (r_ops != '1) begin
                        r_ops <= r_ops + COUNTER_WIDTH'(1);
                    end
                    r_lat_sum <= w_lat_add[TOTAL_WIDTH] ? '1 : w_lat_add[TOTAL_WIDTH-1:0];
                    if (i_amount_us > r_peak) begin
                        r_peak <= i_amount_us;
                    end
                end
                wlm_pkg::OP_CONTEND: begin
                    if (r_conts != '1) begin
                        r_conts <= r_conts + COUNTER_WIDTH'(1);
                    end
                    r_wait_sum <= w_wait_add[TOTAL_WIDTH] ? '1 : w_wait_add[TOTAL_WIDTH-1:0];
                end
                default: begin
                    // Queries and unknown codes leave the window as it is.
                end
            endcase
        end
    end

    assign o_elapsed_ms         = r_elapsed;
    assign o_op_counter         = r_ops;
    assign o_contention_counter = r_conts;
    assign o_latency_sum        = r_lat_sum;
    assign o_wait_sum           = r_wait_sum;
    assign o_latency_peak       = r_peak;

endmodule

FILE: rtl/windowed_load_monitor.sv
// ----------------------------------------------------------------------------
// Windowed load monitor
// Tracks per-window load statistics and answers queries with rates,
// contention percentage and a switch recommendation.
// ----------------------------------------------------------------------------
// An event word's result is loaded into the result register after the word is taken; a query's
// result follows two bit-serial divisions on the shared divider, one quotient bit per cycle,
// and a zero elapsed time or operation count skips its division. The block takes no new word
// until the result of the previous word has been loaded into the result register.
// Reset (synchronous, active low) clears the window and loads the register defaults.
module windowed_load_monitor #(
    parameter int COUNTER_WIDTH = wlm_pkg::COUNTER_WIDTH_DEF,
    parameter int TOTAL_WIDTH   = wlm_pkg::TOTAL_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Event channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [wlm_pkg::OP_W-1:0]        i_operation,
    input  logic [wlm_pkg::AMOUNT_W-1:0]    i_amount_us,
    // Result channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_switch_flag,
    output logic [wlm_pkg::OPS_W-1:0]       o_ops_per_second,
    output logic [wlm_pkg::PEAK_W-1:0]      o_worst_latency_us,
    output logic [wlm_pkg::PCT_W-1:0]       o_contention_percent_q8,
    output logic [wlm_pkg::OUT_CNT_W-1:0]   o_window_ops,
    output logic [wlm_pkg::OUT_CNT_W-1:0]   o_window_contentions,
    output logic [wlm_pkg::OUT_SUM_W-1:0]   o_window_latency_total_us,
    output logic [wlm_pkg::OUT_SUM_W-1:0]   o_window_wait_total_us,
    output logic                            o_rolled_over,
    // Configuration port
    input  logic                            i_cfg_we,
    input  logic [wlm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wlm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int NUM_W  = COUNTER_WIDTH + wlm_pkg::PCT_Q8_SCALE_W;
    localparam int DEN_W  = (COUNTER_WIDTH > wlm_pkg::ELAPSED_W) ?
                            COUNTER_WIDTH : wlm_pkg::ELAPSED_W;
    localparam int PROD_W = COUNTER_WIDTH + wlm_pkg::PCT_LIM_W;
    localparam int EXT_W  = (NUM_W > wlm_pkg::OPS_W) ? NUM_W : wlm_pkg::OPS_W;

    // Configuration registers
    logic [wlm_pkg::CORE_W-1:0]    r_core_count;
    logic [wlm_pkg::CORE_W-1:0]    r_core_threshold;
    logic [wlm_pkg::LIMIT_W-1:0]   r_rate_limit;
    logic [wlm_pkg::PCT_LIM_W-1:0] r_cont_limit;
    logic [wlm_pkg::LIMIT_W-1:0]   r_latency_limit;
    logic [wlm_pkg::WLEN_W-1:0]    r_window_length;

    // Sequencer
    wlm_pkg::t_state r_state;
    wlm_pkg::t_state n_state;
    logic            w_accept;
    logic            w_div_start;
    logic            w_load_out;

    // Window state
    logic                          w_roll_due;
    logic [wlm_pkg::ELAPSED_W-1:0] w_elapsed;
    logic [COUNTER_WIDTH-1:0]      w_ops;
    logic [COUNTER_WIDTH-1:0]      w_conts;
    logic [TOTAL_WIDTH-1:0]        w_lat_sum;
    logic [TOTAL_WIDTH-1:0]        w_wait_sum;
    logic [wlm_pkg::PEAK_W-1:0]    w_peak;

    // Query datapath
    logic                          r_query;
    logic                          r_rolled;
    logic [NUM_W-1:0]              r_num_rate;
    logic [NUM_W-1:0]              r_num_pct;
    logic [PROD_W-1:0]             r_prod_cont;
    logic [PROD_W-1:0]             r_prod_ops;
    logic [wlm_pkg::OPS_W-1:0]     r_ops_ps;
    logic [wlm_pkg::PCT_W-1:0]     r_pct;
    logic                          r_flag;
    logic [wlm_pkg::PEAK_W-1:0]    r_worst;

    // Shared divider
    logic [NUM_W-1:0]              w_div_numer;
    logic [DEN_W-1:0]              w_div_denom;
    logic                          w_div_busy;
    logic                          w_div_done;
    logic [NUM_W-1:0]              w_div_quot;
    logic [EXT_W-1:0]              w_quot_ext;

    // Result register
    logic                          r_out_valid;
    logic                          r_out_flag;
    logic [wlm_pkg::OPS_W-1:0]     r_out_ops_ps;
    logic [wlm_pkg::PEAK_W-1:0]    r_out_worst;
    logic [wlm_pkg::PCT_W-1:0]     r_out_pct;
    logic [wlm_pkg::OUT_CNT_W-1:0] r_out_ops;
    logic [wlm_pkg::OUT_CNT_W-1:0] r_out_conts;
    logic [wlm_pkg::OUT_SUM_W-1:0] r_out_lat_sum;
    logic [wlm_pkg::OUT_SUM_W-1:0] r_out_wait_sum;
    logic                          r_out_rolled;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core_count     <= wlm_pkg::CORE_COUNT_RST;
            r_core_threshold <= wlm_pkg::CORE_THRESHOLD_RST;
            r_rate_limit     <= wlm_pkg::RATE_LIMIT_RST;
            r_cont_limit     <= wlm_pkg::CONT_LIMIT_RST;
            r_latency_limit  <= wlm_pkg::LATENCY_LIMIT_RST;
            r_window_length  <= wlm_pkg::WINDOW_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wlm_pkg::CFG_CORE_COUNT: begin
                    r_core_count <= i_cfg_data[wlm_pkg::CORE_W-1:0];
                end
                wlm_pkg::CFG_CORE_THRESHOLD: begin
                    r_core_threshold <= i_cfg_data[wlm_pkg::CORE_W-1:0];
                end
                wlm_pkg::CFG_RATE_LIMIT: begin
                    r_rate_limit <= i_cfg_data[wlm_pkg::LIMIT_W-1:0];
                end
                wlm_pkg::CFG_CONT_LIMIT: begin
                    r_cont_limit <= i_cfg_data[wlm_pkg::PCT_LIM_W-1:0];
                end
                wlm_pkg::CFG_LATENCY_LIMIT: begin
                    r_latency_limit <= i_cfg_data[wlm_pkg::LIMIT_W-1:0];
                end
                wlm_pkg::CFG_WINDOW_LENGTH: begin
                    r_window_length <= i_cfg_data[wlm_pkg::WLEN_W-1:0];
                end
                default: begin
                    // Indexes past the register list are ignored.
                end
            endcase
        end
    end

    assign w_accept = i_valid && o_ready;

    // Window state, updated at the edge where an event word is taken.
    wlm_window #(
        .COUNTER_WIDTH (COUNTER_WIDTH),
        .TOTAL_WIDTH   (TOTAL_WIDTH)
    ) u_window (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_apply              (w_accept),
        .i_operation          (i_operation),
        .i_amount_us          (i_amount_us),
        .i_window_length_ms   (r_window_length),
        .o_roll_due           (w_roll_due),
        .o_elapsed_ms         (w_elapsed),
        .o_op_counter         (w_ops),
        .o_contention_counter (w_conts),
        .o_latency_sum        (w_lat_sum),
        .o_wait_sum           (w_wait_sum),
        .o_latency_peak       (w_peak)
    );

    // The divider serves the rate first, then the contention percentage.
    always_comb begin
        if (r_state == wlm_pkg::S_DIV_PCT) begin
            w_div_numer = r_num_pct;
            w_div_denom = DEN_W'(w_ops);
        end else begin
            w_div_numer = r_num_rate;
            w_div_denom = DEN_W'(w_elapsed);
        end
    end

    wlm_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_numer (w_div_numer),
        .i_denom (w_div_denom),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    assign w_quot_ext = EXT_W'(w_div_quot);

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wlm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state and strobes.
    always_comb begin
        n_state     = r_state;
        o_ready     = 1'b0;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            wlm_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = (i_operation == wlm_pkg::OP_QUERY) ?
                              wlm_pkg::S_PREP : wlm_pkg::S_EMIT;
                end
            end
            wlm_pkg::S_PREP: begin
                n_state = wlm_pkg::S_DIV_RATE;
            end
            wlm_pkg::S_DIV_RATE: begin
                if (w_elapsed != '0) begin
                    w_div_start = 1'b1;
                    n_state     = wlm_pkg::S_WAIT_RATE;
                end else begin
                    n_state = wlm_pkg::S_DIV_PCT;
                end
            end
            wlm_pkg::S_WAIT_RATE: begin
                if (w_div_done) begin
                    n_state = wlm_pkg::S_DIV_PCT;
                end
            end
            wlm_pkg::S_DIV_PCT: begin
                if (w_ops != '0) begin
                    w_div_start = 1'b1;
                    n_state     = wlm_pkg::S_WAIT_PCT;
                end else begin
                    n_state = wlm_pkg::S_DECIDE;
                end
            end
            wlm_pkg::S_WAIT_PCT: begin
                if (w_div_done) begin
                    n_state = wlm_pkg::S_DECIDE;
                end
            end
            wlm_pkg::S_DECIDE: begin
                n_state = wlm_pkg::S_EMIT;
            end
            wlm_pkg::S_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    w_load_out = 1'b1;
                    n_state    = wlm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wlm_pkg::S_IDLE;
            end
        endcase
    end

    // Query datapath: scaled numerators, saturated quotients and the decision.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_query  <= (i_operation == wlm_pkg::OP_QUERY);
            r_rolled <= (i_operation == wlm_pkg::OP_START) && w_roll_due;
        end
        if (r_state == wlm_pkg::S_PREP) begin
            r_num_rate  <= NUM_W'(w_ops) * NUM_W'(wlm_pkg::RATE_SCALE);
            r_num_pct   <= NUM_W'(w_conts) * NUM_W'(wlm_pkg::PCT_Q8_SCALE);
            r_prod_cont <= PROD_W'(w_conts) * PROD_W'(wlm_pkg::PCT_SCALE);
            r_prod_ops  <= PROD_W'(w_ops) * PROD_W'(r_cont_limit);
            r_ops_ps    <= '0;
            r_pct       <= '0;
        end
        if (r_state == wlm_pkg::S_WAIT_RATE && w_div_done) begin
            r_ops_ps <= (|(w_quot_ext >> wlm_pkg::OPS_W)) ? '1 :
                        w_quot_ext[wlm_pkg::OPS_W-1:0];
        end
        if (r_state == wlm_pkg::S_WAIT_PCT && w_div_done) begin
            r_pct <= (|(w_div_quot >> wlm_pkg::PCT_W)) ? '1 :
                     w_div_quot[wlm_pkg::PCT_W-1:0];
        end
        if (r_state == wlm_pkg::S_DECIDE) begin
            r_worst <= (w_ops != '0) ? w_peak : '0;
            r_flag  <= (r_core_count >= r_core_threshold) &&
                       ((r_ops_ps > wlm_pkg::OPS_W'(r_rate_limit)) ||
                        ((w_ops != '0) && (r_prod_cont > r_prod_ops)) ||
                        ((w_ops != '0) && (w_peak > r_latency_limit)));
        end
    end

    // Result register; it holds a word until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_flag     <= r_query && r_flag;
            r_out_ops_ps   <= r_query ? r_ops_ps : '0;
            r_out_worst    <= r_query ? r_worst : '0;
            r_out_pct      <= r_query ? r_pct : '0;
            r_out_ops      <= wlm_pkg::OUT_CNT_W'(w_ops);
            r_out_conts    <= wlm_pkg::OUT_CNT_W'(w_conts);
            r_out_lat_sum  <= wlm_pkg::OUT_SUM_W'(w_lat_sum);
            r_out_wait_sum <= wlm_pkg::OUT_SUM_W'(w_wait_sum);
            r_out_rolled   <= r_rolled;
        end
    end

    assign o_valid                   = r_out_valid;
    assign o_switch_flag             = r_out_flag;
    assign o_ops_per_second          = r_out_ops_ps;
    assign o_worst_latency_us        = r_out_worst;
    assign o_contention_percent_q8   = r_out_pct;
    assign o_window_ops              = r_out_ops;
    assign o_window_contentions      = r_out_conts;
    assign o_window_latency_total_us = r_out_lat_sum;
    assign o_window_wait_total_us    = r_out_wait_sum;
    assign o_rolled_over             = r_out_rolled;

    // The divider is never restarted while a division is running.
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider started while busy");

    // An event word other than a query goes straight to the result stage.
    a_event_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_operation != wlm_pkg::OP_QUERY) |=> r_state == wlm_pkg::S_EMIT)
        else $error("event word did not go to the result stage");

    // A finished word waits while the previous result is still held.
    a_emit_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wlm_pkg::S_EMIT && r_out_valid && !i_ready)
        |=> r_state == wlm_pkg::S_EMIT)
        else $error("result overwritten before it was taken");

    // A rollover word is an operation start, never a recommendation.
    a_roll_no_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_rolled && r_out_flag))
        else $error("rollover and switch flag in the same word");

endmodule

FILE: sim/windowed_load_monitor_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed load monitor testbench
// Drives event words through the valid/ready input channel and checks every
// result word against a cycle-free predictor of the window statistics. A short
// directed table covers reset values, field extremes, reserved operation codes,
// zero window length, zero elapsed time and an empty window. Random phases then
// run under several register settings and idling patterns on both channels.
// ----------------------------------------------------------------------------
module windowed_load_monitor_test;

    // Operation codes that the block treats as no-ops.
    localparam int RSVD_OP_LO = 5;
    localparam int RSVD_OP_HI = 7;
    localparam logic [wlm_pkg::OP_W-1:0] OP_RSVD_A = wlm_pkg::OP_W'(RSVD_OP_LO);
    localparam logic [wlm_pkg::OP_W-1:0] OP_RSVD_B = wlm_pkg::OP_W'(6);
    localparam logic [wlm_pkg::OP_W-1:0] OP_RSVD_C = wlm_pkg::OP_W'(RSVD_OP_HI);

    localparam int CNT_W = wlm_pkg::COUNTER_WIDTH_DEF;
    localparam int SUM_W = wlm_pkg::TOTAL_WIDTH_DEF;

    localparam logic [63:0] OPS_CAP = (64'd1 << wlm_pkg::OPS_W) - 64'd1;
    localparam logic [63:0] PCT_CAP = (64'd1 << wlm_pkg::PCT_W) - 64'd1;

    localparam int RESET_CYCLES    = 9;
    localparam int NUM_PHASES      = 12;
    localparam int WORDS_PER_PHASE = 82;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 150;
    localparam int WATCHDOG_LIMIT  = 5000;

    // One result word, in port order.
    typedef struct packed {
        logic                          switch_flag;
        logic [wlm_pkg::OPS_W-1:0]     ops_per_second;
        logic [wlm_pkg::PEAK_W-1:0]    worst_latency_us;
        logic [wlm_pkg::PCT_W-1:0]     contention_percent_q8;
        logic [wlm_pkg::OUT_CNT_W-1:0] window_ops;
        logic [wlm_pkg::OUT_CNT_W-1:0] window_contentions;
        logic [wlm_pkg::OUT_SUM_W-1:0] latency_total_us;
        logic [wlm_pkg::OUT_SUM_W-1:0] wait_total_us;
        logic                          rolled_over;
    } t_load_report;

    // One row of the directed table: a register write or an event word.
    typedef struct {
        bit                             is_cfg;
        logic [wlm_pkg::CFG_IDX_W-1:0]  reg_index;
        logic [wlm_pkg::CFG_DATA_W-1:0] reg_data;
        logic [wlm_pkg::OP_W-1:0]       operation;
        logic [wlm_pkg::AMOUNT_W-1:0]   amount;
        bit                             typed;
        t_load_report                   want;
    } t_stim_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_ready;
    logic [wlm_pkg::OP_W-1:0]       i_operation;
    logic [wlm_pkg::AMOUNT_W-1:0]   i_amount_us;
    logic                           o_valid;
    logic                           i_ready;
    logic                           o_switch_flag;
    logic [wlm_pkg::OPS_W-1:0]      o_ops_per_second;
    logic [wlm_pkg::PEAK_W-1:0]     o_worst_latency_us;
    logic [wlm_pkg::PCT_W-1:0]      o_contention_percent_q8;
    logic [wlm_pkg::OUT_CNT_W-1:0]  o_window_ops;
    logic [wlm_pkg::OUT_CNT_W-1:0]  o_window_contentions;
    logic [wlm_pkg::OUT_SUM_W-1:0]  o_window_latency_total_us;
    logic [wlm_pkg::OUT_SUM_W-1:0]  o_window_wait_total_us;
    logic                           o_rolled_over;
    logic                           i_cfg_we;
    logic [wlm_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [wlm_pkg::CFG_DATA_W-1:0] i_cfg_data;

    windowed_load_monitor dut (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_valid                   (i_valid),
        .o_ready                   (o_ready),
        .i_operation               (i_operation),
        .i_amount_us               (i_amount_us),
        .o_valid                   (o_valid),
        .i_ready                   (i_ready),
        .o_switch_flag             (o_switch_flag),
        .o_ops_per_second          (o_ops_per_second),
        .o_worst_latency_us        (o_worst_latency_us),
        .o_contention_percent_q8   (o_contention_percent_q8),
        .o_window_ops              (o_window_ops),
        .o_window_contentions      (o_window_contentions),
        .o_window_latency_total_us (o_window_latency_total_us),
        .o_window_wait_total_us    (o_window_wait_total_us),
        .o_rolled_over             (o_rolled_over),
        .i_cfg_we                  (i_cfg_we),
        .i_cfg_index               (i_cfg_index),
        .i_cfg_data                (i_cfg_data)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predicted window state and register copies.
    logic [wlm_pkg::ELAPSED_W-1:0] elapsed_ms;
    logic [CNT_W-1:0]              ended_ops;
    logic [CNT_W-1:0]              contention_count;
    logic [SUM_W-1:0]              latency_sum;
    logic [SUM_W-1:0]              wait_sum;
    logic [wlm_pkg::PEAK_W-1:0]    latency_peak;

    logic [wlm_pkg::CORE_W-1:0]    cfg_core_count;
    logic [wlm_pkg::CORE_W-1:0]    cfg_core_threshold;
    logic [wlm_pkg::LIMIT_W-1:0]   cfg_rate_limit;
    logic [wlm_pkg::PCT_LIM_W-1:0] cfg_contention_limit;
    logic [wlm_pkg::LIMIT_W-1:0]   cfg_latency_limit;
    logic [wlm_pkg::WLEN_W-1:0]    cfg_window_length;

    t_load_report expected_reports[$];
    t_stim_row    stim_table[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int words_sent     = 0;
    int queries_sent   = 0;
    int rollovers_seen = 0;
    int switches_seen  = 0;
    int settings_used  = 1;
    int quiet_cycles   = 0;

    function automatic void clear_window_state();
        elapsed_ms       = '0;
        ended_ops        = '0;
        contention_count = '0;
        latency_sum      = '0;
        wait_sum         = '0;
        latency_peak     = '0;
    endfunction

    function automatic logic [SUM_W-1:0] add_saturated(logic [SUM_W-1:0] total,
                                                       logic [wlm_pkg::AMOUNT_W-1:0] amount);
        logic [SUM_W:0] sum;
        sum = {1'b0, total} + (SUM_W+1)'(amount);
        return sum[SUM_W] ? '1 : sum[SUM_W-1:0];
    endfunction

    // Apply one event word to the predicted state and return its result word.
    function automatic t_load_report predict_report(logic [wlm_pkg::OP_W-1:0] operation,
                                                    logic [wlm_pkg::AMOUNT_W-1:0] amount);
        t_load_report report;
        logic [63:0]  quotient;
        logic         over_contention;
        report          = '0;
        over_contention = 1'b0;
        case (operation)
            wlm_pkg::OP_TICK: begin
                if (elapsed_ms != '1) elapsed_ms = elapsed_ms + wlm_pkg::ELAPSED_W'(1);
            end
            wlm_pkg::OP_START: begin
                if (elapsed_ms >= wlm_pkg::ELAPSED_W'(cfg_window_length)) begin
                    clear_window_state();
                    report.rolled_over = 1'b1;
                end
            end
            wlm_pkg::OP_END: begin
                if (ended_ops != '1) ended_ops = ended_ops + CNT_W'(1);
                latency_sum = add_saturated(latency_sum, amount);
                if (amount > latency_peak) latency_peak = amount;
            end
            wlm_pkg::OP_CONTEND: begin
                if (contention_count != '1) contention_count = contention_count + CNT_W'(1);
                wait_sum = add_saturated(wait_sum, amount);
            end
            wlm_pkg::OP_QUERY: begin
                if (elapsed_ms != '0) begin
                    quotient = (64'(ended_ops) * 64'(wlm_pkg::RATE_SCALE)) /
                               64'(elapsed_ms);
                    report.ops_per_second = (quotient > OPS_CAP) ?
                                            OPS_CAP[wlm_pkg::OPS_W-1:0] :
                                            quotient[wlm_pkg::OPS_W-1:0];
                end
                if (ended_ops != '0) begin
                    report.worst_latency_us = latency_peak;
                    quotient = (64'(contention_count) * 64'(wlm_pkg::PCT_Q8_SCALE)) /
                               64'(ended_ops);
                    report.contention_percent_q8 = (quotient > PCT_CAP) ?
                                                   PCT_CAP[wlm_pkg::PCT_W-1:0] :
                                                   quotient[wlm_pkg::PCT_W-1:0];
                    over_contention = (64'(contention_count) * 64'(wlm_pkg::PCT_SCALE)) >
                                      (64'(ended_ops) * 64'(cfg_contention_limit));
                end
                report.switch_flag = (cfg_core_count >= cfg_core_threshold) &&
                    ((64'(report.ops_per_second) > 64'(cfg_rate_limit)) || over_contention ||
                     (report.worst_latency_us > cfg_latency_limit));
            end
            default: ;
        endcase
        report.window_ops         = wlm_pkg::OUT_CNT_W'(ended_ops);
        report.window_contentions = wlm_pkg::OUT_CNT_W'(contention_count);
        report.latency_total_us   = wlm_pkg::OUT_SUM_W'(latency_sum);
        report.wait_total_us      = wlm_pkg::OUT_SUM_W'(wait_sum);
        return report;
    endfunction

    function automatic t_stim_row word_row(logic [wlm_pkg::OP_W-1:0] operation,
                                           logic [wlm_pkg::AMOUNT_W-1:0] amount,
                                           bit typed = 1'b0,
                                           t_load_report want = '0);
        t_stim_row row;
        row           = '{default: '0};
        row.operation = operation;
        row.amount    = amount;
        row.typed     = typed;
        row.want      = want;
        return row;
    endfunction

    function automatic t_stim_row reg_row(logic [wlm_pkg::CFG_IDX_W-1:0] index,
                                          logic [wlm_pkg::CFG_DATA_W-1:0] data);
        t_stim_row row;
        row           = '{default: '0};
        row.is_cfg    = 1'b1;
        row.reg_index = index;
        row.reg_data  = data;
        return row;
    endfunction

    function automatic logic [wlm_pkg::AMOUNT_W-1:0] pick_amount();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom();
            default: return $urandom_range(0, 20000);
        endcase
    endfunction

    // Mostly well-formed traffic, with a few reserved codes mixed in.
    function automatic logic [wlm_pkg::OP_W-1:0] pick_operation();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30) return wlm_pkg::OP_TICK;
        if (roll < 40) return wlm_pkg::OP_START;
        if (roll < 62) return wlm_pkg::OP_END;
        if (roll < 80) return wlm_pkg::OP_CONTEND;
        if (roll < 96) return wlm_pkg::OP_QUERY;
        return wlm_pkg::OP_W'($urandom_range(RSVD_OP_LO, RSVD_OP_HI));
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("mismatch on %s at %0t: got %h, want %h", what, $realtime, got, want);
    endtask

    task automatic check_report(t_load_report got, t_load_report want);
        if (got.switch_flag !== want.switch_flag)
            report_mismatch("switch_flag", 64'(got.switch_flag), 64'(want.switch_flag));
        if (got.ops_per_second !== want.ops_per_second)
            report_mismatch("ops_per_second", 64'(got.ops_per_second),
                            64'(want.ops_per_second));
        if (got.worst_latency_us !== want.worst_latency_us)
            report_mismatch("worst_latency_us", 64'(got.worst_latency_us),
                            64'(want.worst_latency_us));
        if (got.contention_percent_q8 !== want.contention_percent_q8)
            report_mismatch("contention_percent_q8", 64'(got.contention_percent_q8),
                            64'(want.contention_percent_q8));
        if (got.window_ops !== want.window_ops)
            report_mismatch("window_ops", 64'(got.window_ops), 64'(want.window_ops));
        if (got.window_contentions !== want.window_contentions)
            report_mismatch("window_contentions", 64'(got.window_contentions),
                            64'(want.window_contentions));
        if (got.latency_total_us !== want.latency_total_us)
            report_mismatch("window_latency_total_us", 64'(got.latency_total_us),
                            64'(want.latency_total_us));
        if (got.wait_total_us !== want.wait_total_us)
            report_mismatch("window_wait_total_us", 64'(got.wait_total_us),
                            64'(want.wait_total_us));
        if (got.rolled_over !== want.rolled_over)
            report_mismatch("rolled_over", 64'(got.rolled_over), 64'(want.rolled_over));
    endtask

    // Offer one word, with random gaps ahead of it, and record its expected result.
    task automatic send_word(logic [wlm_pkg::OP_W-1:0] operation,
                             logic [wlm_pkg::AMOUNT_W-1:0] amount,
                             bit typed = 1'b0, t_load_report want = '0);
        t_load_report predicted;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= operation;
        i_amount_us <= amount;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predicted = predict_report(operation, amount);
        expected_reports.push_back(typed ? want : predicted);
        words_sent++;
        if (operation == wlm_pkg::OP_QUERY) queries_sent++;
        if (predicted.rolled_over) rollovers_seen++;
        if (predicted.switch_flag) switches_seen++;
    endtask

    // Drop valid and let every outstanding result drain.
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [wlm_pkg::CFG_IDX_W-1:0] index,
                             logic [wlm_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            wlm_pkg::CFG_CORE_COUNT:     cfg_core_count = data[wlm_pkg::CORE_W-1:0];
            wlm_pkg::CFG_CORE_THRESHOLD: cfg_core_threshold = data[wlm_pkg::CORE_W-1:0];
            wlm_pkg::CFG_RATE_LIMIT:     cfg_rate_limit = data[wlm_pkg::LIMIT_W-1:0];
            wlm_pkg::CFG_CONT_LIMIT:     cfg_contention_limit = data[wlm_pkg::PCT_LIM_W-1:0];
            wlm_pkg::CFG_LATENCY_LIMIT:  cfg_latency_limit = data[wlm_pkg::LIMIT_W-1:0];
            wlm_pkg::CFG_WINDOW_LENGTH:  cfg_window_length = data[wlm_pkg::WLEN_W-1:0];
            default: ;
        endcase
    endtask

    // Register setting of a random phase: the first uses the low extremes,
    // the second the high extremes, the rest random values with short windows.
    task automatic apply_settings(int phase);
        logic [wlm_pkg::CFG_DATA_W-1:0] cores, threshold, rate, contention, latency, window;
        case (phase)
            0: begin
                cores = 1; threshold = 1; rate = 0; contention = 0; latency = 0; window = 1;
            end
            1: begin
                cores = 1024; threshold = 1024; rate = '1; contention = 1000;
                latency = '1; window = 65535;
            end
            default: begin
                cores      = $urandom_range(1, 1024);
                threshold  = ($urandom_range(3) == 0) ? $urandom_range(1, 1024)
                                                      : $urandom_range(1, cores);
                rate       = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 200000);
                contention = $urandom_range(0, 1000);
                latency    = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 25000);
                window     = $urandom_range(1, 12);
            end
        endcase
        write_reg(wlm_pkg::CFG_CORE_COUNT, cores);
        write_reg(wlm_pkg::CFG_CORE_THRESHOLD, threshold);
        write_reg(wlm_pkg::CFG_RATE_LIMIT, rate);
        write_reg(wlm_pkg::CFG_CONT_LIMIT, contention);
        write_reg(wlm_pkg::CFG_LATENCY_LIMIT, latency);
        write_reg(wlm_pkg::CFG_WINDOW_LENGTH, window);
        settings_used++;
    endtask

    // Receiver: random back-pressure, changed at the falling edge.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker and watchdog, both on the rising edge.
    always @(posedge i_clk) begin
        t_load_report got;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_switch_flag, o_ops_per_second, o_worst_latency_us,
                   o_contention_percent_q8, o_window_ops, o_window_contentions,
                   o_window_latency_total_us, o_window_wait_total_us, o_rolled_over};
            if (expected_reports.size() == 0)
                report_mismatch("unexpected result word", 64'(got.window_ops), '0);
            else
                check_report(got, expected_reports.pop_front());
        end
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no word moved for %0d cycles, %0d results outstanding",
                         WATCHDOG_LIMIT, expected_reports.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Stimulus: directed table, then random phases.
    initial begin
        t_load_report want;
        t_stim_row    row;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_operation = wlm_pkg::OP_TICK;
        i_amount_us = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = wlm_pkg::CFG_CORE_COUNT;
        i_cfg_data  = '0;
        clear_window_state();
        cfg_core_count       = wlm_pkg::CORE_COUNT_RST;
        cfg_core_threshold   = wlm_pkg::CORE_THRESHOLD_RST;
        cfg_rate_limit       = wlm_pkg::RATE_LIMIT_RST;
        cfg_contention_limit = wlm_pkg::CONT_LIMIT_RST;
        cfg_latency_limit    = wlm_pkg::LATENCY_LIMIT_RST;
        cfg_window_length    = wlm_pkg::WINDOW_LENGTH_RST;

        // Reset values, reserved codes and a start inside the window all give
        // an all-zero result.
        stim_table.push_back(word_row(wlm_pkg::OP_QUERY, '0, 1'b1, '0));
        stim_table.push_back(word_row(OP_RSVD_A, '1, 1'b1, '0));
        stim_table.push_back(word_row(OP_RSVD_B, '0, 1'b1, '0));
        stim_table.push_back(word_row(OP_RSVD_C, 32'hAAAA_AAAA, 1'b1, '0));
        stim_table.push_back(word_row(wlm_pkg::OP_START, '0, 1'b1, '0));
        // Largest latency on the first ended operation.
        want                  = '0;
        want.window_ops       = 1;
        want.latency_total_us = 48'h0000_FFFF_FFFF;
        stim_table.push_back(word_row(wlm_pkg::OP_END, '1, 1'b1, want));
        stim_table.push_back(word_row(wlm_pkg::OP_END, '0));
        stim_table.push_back(word_row(wlm_pkg::OP_CONTEND, '1));
        stim_table.push_back(word_row(wlm_pkg::OP_CONTEND, '0));
        // Query with no elapsed time, then after one tick.
        stim_table.push_back(word_row(wlm_pkg::OP_QUERY, 32'h5555_5555));
        stim_table.push_back(word_row(wlm_pkg::OP_TICK, 32'h5555_5555));
        stim_table.push_back(word_row(wlm_pkg::OP_QUERY, '0));
        // Zero window length with every limit at its low end.
        stim_table.push_back(reg_row(wlm_pkg::CFG_WINDOW_LENGTH, '0));
        stim_table.push_back(reg_row(wlm_pkg::CFG_CORE_COUNT, 1024));
        stim_table.push_back(reg_row(wlm_pkg::CFG_CORE_THRESHOLD, 1));
        stim_table.push_back(reg_row(wlm_pkg::CFG_RATE_LIMIT, '0));
        stim_table.push_back(reg_row(wlm_pkg::CFG_CONT_LIMIT, '0));
        stim_table.push_back(reg_row(wlm_pkg::CFG_LATENCY_LIMIT, '0));
        stim_table.push_back(word_row(wlm_pkg::OP_START, '0));
        stim_table.push_back(word_row(wlm_pkg::OP_START, '0));
        // Empty window: no elapsed time and no operations.
        stim_table.push_back(word_row(wlm_pkg::OP_QUERY, '0, 1'b1, '0));
        stim_table.push_back(word_row(wlm_pkg::OP_TICK, '0));
        stim_table.push_back(word_row(wlm_pkg::OP_END, 7));
        stim_table.push_back(word_row(wlm_pkg::OP_CONTEND, 3));
        stim_table.push_back(word_row(wlm_pkg::OP_QUERY, '0));

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[k]) begin
            row = stim_table[k];
            if (row.is_cfg) begin
                wait_idle();
                write_reg(row.reg_index, row.reg_data);
            end else begin
                send_word(row.operation, row.amount, row.typed, row.want);
            end
        end

        // Random phases, rotating through the idling patterns.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_idle();
            apply_settings(phase);
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                send_word(pick_operation(), pick_amount());
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d event words (%0d queries) under %0d register settings.",
                 words_sent, queries_sent, settings_used);
        $display("Predicted %0d window rollovers and %0d switch recommendations.",
                 rollovers_seen, switches_seen);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
